### rtl/core/fircb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter package
// Shared constants and control/status types of the circular-buffer FIR.
// ----------------------------------------------------------------------------
package fircb_pkg;

  // accumulator width, products wrap modulo 2^ACC_BITS
  localparam int ACC_BITS = 40;

  // input item kinds (tuser)
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FILTER = 1'b1;

  // configuration register index
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef struct packed {
    logic clr;       // clear accumulator, new sample started
    logic data_vld;  // sample and coefficient operands valid this cycle
  } mac_ctl_t;

  typedef struct packed {
    logic busy;      // product stage holds a term not yet accumulated
  } mac_sts_t;

endpackage

### rtl/core/fircb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fircb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fircb_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Shared multiplier with a product register, wrapping accumulator, and
// round-half-up / saturate of the accumulated sum to the sample format.
// ----------------------------------------------------------------------------
module fircb_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fircb_pkg::mac_ctl_t           ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_i,
  output fircb_pkg::mac_sts_t           sts_o,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output logic                          sat_o
);
  import fircb_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int EXT_W  = (PROD_W > ACC_BITS) ? PROD_W : ACC_BITS;
  localparam logic signed [ACC_BITS:0] HI =
      (ACC_BITS+1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_BITS:0] LO = -HI - (ACC_BITS+1)'(1);
  localparam logic signed [ACC_BITS:0] RND =
      (ACC_BITS+1)'(64'd1 << (SAMPLE_BITS - 2));

  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       prod_vld_q;
  logic signed [EXT_W-1:0]    prod_ext;
  logic [ACC_BITS-1:0]        acc_q, acc_d;
  logic signed [ACC_BITS:0]   acc_ext;
  logic signed [ACC_BITS:0]   rnd_sum;
  logic signed [ACC_BITS:0]   rnd_shr;

  assign prod_d   = smp_i * coef_i;
  assign prod_ext = EXT_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_ext[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.data_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_vld) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // round half up, then clamp
  assign acc_ext = (ACC_BITS+1)'($signed(acc_q));
  assign rnd_sum = acc_ext + RND;
  assign rnd_shr = rnd_sum >>> (SAMPLE_BITS - 1);

  always_comb begin
    sat_o      = 1'b0;
    filtered_o = rnd_shr[SAMPLE_BITS-1:0];
    if (rnd_shr > HI) begin
      sat_o      = 1'b1;
      filtered_o = HI[SAMPLE_BITS-1:0];
    end else if (rnd_shr < LO) begin
      sat_o      = 1'b1;
      filtered_o = LO[SAMPLE_BITS-1:0];
    end
  end

  assign sts_o.busy = prod_vld_q;

  a_busy_follows_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
      sts_o.busy |-> $past(ctl_i.data_vld))
    else $error("product stage valid without operands");

endmodule

### rtl/core/fircb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR sequencer
// Owns the sample ring and coefficient store, clears them after reset,
// writes items and walks the taps one per cycle into the MAC unit.
// ----------------------------------------------------------------------------
module fircb_ctrl #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic                               action_i,
  input  logic [6:0]                         coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0]      value_i,
  input  logic [$clog2(MAX_TAPS+1)-1:0]      taps_i,
  input  logic                               out_free_i,
  output logic                               fin_o,
  output fircb_pkg::mac_ctl_t                ctl_o,
  input  fircb_pkg::mac_sts_t                sts_i,
  output logic signed [SAMPLE_BITS-1:0]      smp_o,
  output logic signed [SAMPLE_BITS-1:0]      coef_o
);
  import fircb_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [AW-1:0]          slot_eff;
  logic [AW-1:0]          slot_next;
  logic [AW-1:0]          last_tap;
  logic                   coef_ok;
  logic                   ring_we, coef_we;
  logic [AW-1:0]          ring_waddr, coef_waddr;
  logic [SAMPLE_BITS-1:0] ring_wdata, coef_wdata;
  logic [SAMPLE_BITS-1:0] ring_rdata, coef_rdata;

  assign s_ready_o = (state_q == ST_IDLE);
  assign slot_eff  = (TAP_W'(slot_q) < taps_i) ? slot_q : '0;
  assign slot_next = ((TAP_W'(slot_eff) + TAP_W'(1)) >= taps_i) ? '0 : slot_eff + 1'b1;
  assign last_tap  = AW'(taps_i - 1'b1);
  assign coef_ok   = (32'(coef_index_i) < 32'(MAX_TAPS));

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    pos_d          = pos_q;
    slot_d         = slot_q;
    rd_vld_d       = 1'b0;
    fin_o          = 1'b0;
    ctl_o.clr      = 1'b0;
    ctl_o.data_vld = rd_vld_q;
    ring_we        = 1'b0;
    coef_we        = 1'b0;
    ring_waddr     = cnt_q;
    coef_waddr     = cnt_q;
    ring_wdata     = '0;
    coef_wdata     = '0;
    case (state_q)
      ST_CLEAR: begin
        ring_we = 1'b1;
        coef_we = 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          if (action_i == ACT_FILTER) begin
            ring_we    = 1'b1;
            ring_waddr = slot_eff;
            ring_wdata = value_i;
            pos_d      = slot_eff;
            cnt_d      = '0;
            slot_d     = slot_next;
            ctl_o.clr  = 1'b1;
            state_d    = ST_WALK;
          end else if (coef_ok) begin
            coef_we    = 1'b1;
            coef_waddr = AW'(coef_index_i);
            coef_wdata = value_i;
          end
        end
      end
      ST_WALK: begin
        rd_vld_d = 1'b1;
        if (cnt_q == last_tap) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
          pos_d = (pos_q == '0) ? last_tap : pos_q - 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !sts_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          fin_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      pos_q    <= '0;
      slot_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      slot_q   <= slot_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  fircb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  fircb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (cnt_q),
    .rdata_o (coef_rdata)
  );

  assign smp_o          = $signed(ring_rdata);
  assign coef_o         = $signed(coef_rdata);

  a_rd_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
      rd_vld_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("tap read outside walk");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ST_DONE |-> (!rd_vld_q && !sts_i.busy))
    else $error("result taken before pipeline drained");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_CLEAR && cnt_q == LAST_ADDR) |=> state_q == ST_IDLE)
    else $error("clear pass did not finish");

endmodule

### rtl/core/fir_filter_circular_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter, circular buffer
// Direct-form FIR with a circular delay line and one shared MAC.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one entry per cycle, and
// takes no item meanwhile; tap_count writes are taken. A coefficient load
// (tuser = 0) is written to the coefficient store and gives no result. For a
// sample (tuser = 1) the single multiply-accumulate walks one tap per cycle
// through the sample ring and coefficient store, then the read and product
// stages drain and, once the output register is free, the rounded, saturated
// result is placed in it, where it waits while the next item is taken. taps
// is tap_count, with 0 read as 1 and values above MAX_TAPS read as MAX_TAPS.
// ----------------------------------------------------------------------------
module fir_filter_circular_buffer #(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // tdata: coef_index[6:0], value, zero fill
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((7+SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // tuser: action
  input  logic                                     s_axis_tuser,
  // tdata: filtered, zero fill
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // tuser: saturated
  output logic                                     m_axis_tuser,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [2:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import fircb_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int CW    = (TAP_W > 8) ? TAP_W : 8;

  logic [7:0]                    tap_count_q;
  logic [CW-1:0]                 tc_ext;
  logic [TAP_W-1:0]              taps;
  logic                          cfg_wr;
  logic                          out_vld_q;
  logic [SAMPLE_BITS-1:0]        out_data_q;
  logic                          out_sat_q;
  logic                          out_free;
  logic                          fin;
  mac_ctl_t                      mac_ctl;
  mac_sts_t                      mac_sts;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] coef;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          sat;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT);
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? {24'd0, tap_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 8'd1;
    end else if (cfg_wr) begin
      tap_count_q <= pwdata[7:0];
    end
  end

  assign tc_ext = CW'(tap_count_q);
  always_comb begin
    if (tc_ext == '0) begin
      taps = TAP_W'(1);
    end else if (tc_ext > CW'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = TAP_W'(tc_ext);
    end
  end

  fircb_ctrl #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .action_i     (s_axis_tuser),
    .coef_index_i (s_axis_tdata[6:0]),
    .value_i      ($signed(s_axis_tdata[7+SAMPLE_BITS-1:7])),
    .taps_i       (taps),
    .out_free_i   (out_free),
    .fin_o        (fin),
    .ctl_o        (mac_ctl),
    .sts_i        (mac_sts),
    .smp_o        (smp),
    .coef_o       (coef)
  );

  fircb_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .smp_i      (smp),
    .coef_i     (coef),
    .sts_o      (mac_sts),
    .filtered_o (filtered),
    .sat_o      (sat)
  );

  // output register
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_data_q <= filtered;
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);
  assign m_axis_tuser  = out_sat_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fin |-> (!out_vld_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule
